>>> rtl/atp_pkg.sv
package atp_pkg;

  // Internal datapath width: 16-bit sample, x256 prescale, CORDIC gain and sign
  localparam int DW = 27;
  // Fraction bits of the internal angle accumulator (degrees * 65536)
  localparam int ACC_FRAC = 16;
  localparam int PRESCALE_SH = 8;
  localparam int TBL_LEN = 24;

  localparam logic signed [DW-1:0] ANG_HALF_TURN = 27'sd11796480;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
  } out_word_t;

  typedef struct packed {
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
    logic signed [DW-1:0] ang;
    logic                 zero;
  } lane_t;

  typedef struct packed {
    lane_t pitch;
    lane_t roll;
  } lane_pair_t;

  // atan(2^-i) in degrees * 65536, rounded
  function automatic logic signed [DW-1:0] atan_tbl(input int idx);
    logic signed [DW-1:0] t;
    case (idx)
      0:  t = 27'sd2949120;
      1:  t = 27'sd1740967;
      2:  t = 27'sd919879;
      3:  t = 27'sd466945;
      4:  t = 27'sd234379;
      5:  t = 27'sd117304;
      6:  t = 27'sd58665;
      7:  t = 27'sd29335;
      8:  t = 27'sd14668;
      9:  t = 27'sd7334;
      10: t = 27'sd3667;
      11: t = 27'sd1833;
      12: t = 27'sd917;
      13: t = 27'sd458;
      14: t = 27'sd229;
      15: t = 27'sd115;
      16: t = 27'sd57;
      17: t = 27'sd29;
      18: t = 27'sd14;
      19: t = 27'sd7;
      20: t = 27'sd4;
      21: t = 27'sd2;
      22: t = 27'sd1;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

>>> rtl/atp_pre.sv
module atp_pre (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  atp_pkg::in_word_t      in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output atp_pkg::lane_pair_t    out_data
);

  logic                valid_r;
  atp_pkg::lane_pair_t data_r;
  atp_pkg::lane_pair_t data_nxt;

  // Fold the left half plane onto the right, seed the start angle, prescale
  function automatic atp_pkg::lane_t fold(input logic signed [15:0] b_in,
                                          input logic signed [15:0] a_in);
    atp_pkg::lane_t       l;
    logic signed [atp_pkg::DW-1:0] a_e;
    logic signed [atp_pkg::DW-1:0] b_e;
    a_e = atp_pkg::DW'(a_in);
    b_e = atp_pkg::DW'(b_in);
    l.zero = (a_in == '0) && (b_in == '0);
    if (a_in < 0) begin
      a_e   = -a_e;
      b_e   = -b_e;
      l.ang = (b_in >= 0) ? atp_pkg::ANG_HALF_TURN : -atp_pkg::ANG_HALF_TURN;
    end else begin
      l.ang = '0;
    end
    l.a = a_e <<< atp_pkg::PRESCALE_SH;
    l.b = b_e <<< atp_pkg::PRESCALE_SH;
    return l;
  endfunction

  always_comb begin
    data_nxt.pitch = fold(in_data.accel_z, in_data.accel_x);
    data_nxt.roll  = fold(in_data.accel_y, in_data.accel_z);
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> rtl/atp_stage.sv
module atp_stage #(
  parameter int SHIFT = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  atp_pkg::lane_pair_t    in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output atp_pkg::lane_pair_t    out_data
);

  localparam logic signed [atp_pkg::DW-1:0] TBL = atp_pkg::atan_tbl(SHIFT);

  logic                valid_r;
  atp_pkg::lane_pair_t data_r;
  atp_pkg::lane_pair_t data_nxt;

  // One vectoring micro-rotation towards the positive x axis
  function automatic atp_pkg::lane_t rotate(input atp_pkg::lane_t l);
    atp_pkg::lane_t o;
    logic signed [atp_pkg::DW-1:0] da;
    logic signed [atp_pkg::DW-1:0] db;
    da = l.b >>> SHIFT;
    db = l.a >>> SHIFT;
    o.zero = l.zero;
    if (l.b > 0) begin
      o.a   = l.a + da;
      o.b   = l.b - db;
      o.ang = l.ang + TBL;
    end else begin
      o.a   = l.a - da;
      o.b   = l.b + db;
      o.ang = l.ang - TBL;
    end
    return o;
  endfunction

  always_comb begin
    data_nxt.pitch = rotate(in_data.pitch);
    data_nxt.roll  = rotate(in_data.roll);
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> rtl/atp_post.sv
module atp_post #(
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  atp_pkg::lane_pair_t    in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output atp_pkg::out_word_t     out_data
);

  localparam int RSH = atp_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [atp_pkg::DW-1:0] HALF_LSB = atp_pkg::DW'(1 << (RSH - 1));
  localparam logic signed [atp_pkg::DW-1:0] LIM = atp_pkg::DW'(180 << ANGLE_FRAC_BITS);

  logic               valid_r;
  atp_pkg::out_word_t data_r;
  atp_pkg::out_word_t data_nxt;

  // Round to output resolution, clamp to +-180 degrees
  function automatic logic signed [15:0] finish(input atp_pkg::lane_t l);
    logic signed [atp_pkg::DW-1:0] r;
    r = (l.ang + HALF_LSB) >>> RSH;
    if (r > LIM) begin
      r = LIM;
    end
    if (r < -LIM) begin
      r = -LIM;
    end
    if (l.zero) begin
      r = '0;
    end
    return r[15:0];
  endfunction

  always_comb begin
    data_nxt.pitch_angle = finish(in_data.pitch);
    data_nxt.roll_angle  = finish(in_data.roll);
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> rtl/accel_tilt_pitch_roll.sv
// Channel   Direction  Word                                  Handshake
// in_       input      accel_x, accel_y, accel_z (s16 each)  in_valid / in_ready
// out_      output     pitch_angle, roll_angle (s16 each)    out_valid / out_ready
//
// One word accepted per cycle while out_ready is held high; the path is registered in the fold
// register, one register per CORDIC micro-rotation, then the round/clamp register.
// Synchronous active-low reset clears only the valid bits of every stage.
// Each stage holds its word until the next takes it, so a stall at out_
// backs up stage by stage; bubbles are squeezed out while stalled.
module accel_tilt_pitch_roll #(
  parameter int CORDIC_STAGES   = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  atp_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output atp_pkg::out_word_t out_data
);

  // micro-rotations beyond the table length are not performed
  localparam int NSTG = (CORDIC_STAGES < atp_pkg::TBL_LEN) ? CORDIC_STAGES
                                                           : atp_pkg::TBL_LEN;

  logic                valid_s [NSTG+1];
  logic                ready_s [NSTG+1];
  atp_pkg::lane_pair_t data_s  [NSTG+1];

  atp_pre u_pre (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (valid_s[0]),
    .out_ready (ready_s[0]),
    .out_data  (data_s[0])
  );

  for (genvar i = 0; i < NSTG; i++) begin : g_stage
    atp_stage #(
      .SHIFT (i)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (valid_s[i]),
      .in_ready  (ready_s[i]),
      .in_data   (data_s[i]),
      .out_valid (valid_s[i+1]),
      .out_ready (ready_s[i+1]),
      .out_data  (data_s[i+1])
    );
  end

  atp_post #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (valid_s[NSTG]),
    .in_ready  (ready_s[NSTG]),
    .in_data   (data_s[NSTG]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> tb/tilt_angle_checker.sv
`timescale 1ns / 1ps

module tilt_angle_checker #(
  parameter int CORDIC_STAGES   = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  atp_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  atp_pkg::out_word_t out_data,
  output int                 err_count,
  output int                 pending
);

  localparam int ROT_TBL_LEN = 24;
  localparam int Q_FRAC      = 16;

  // atan(2^-i) in degrees, 16 fraction bits
  longint atan_deg_q16 [0:ROT_TBL_LEN-1] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58665, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  atp_pkg::out_word_t angle_due [$];

  // four-quadrant atan2(num, den) in degrees with ANGLE_FRAC_BITS fraction bits
  function automatic logic signed [15:0] cordic_atan2_deg(input longint num, input longint den);
    longint a, b, a_prev, ang, r, lim;
    int     i;
    a   = den;
    b   = num;
    ang = 0;
    lim = 64'sd180 <<< ANGLE_FRAC_BITS;
    if (a == 0 && b == 0) return '0;
    if (a < 0) begin
      ang = (b >= 0) ? (64'sd180 <<< Q_FRAC) : -(64'sd180 <<< Q_FRAC);
      a   = -a;
      b   = -b;
    end
    a = a * 256;
    b = b * 256;
    for (i = 0; i < CORDIC_STAGES && i < ROT_TBL_LEN; i++) begin
      a_prev = a;
      if (b > 0) begin
        a   = a + (b >>> i);
        b   = b - (a_prev >>> i);
        ang = ang + atan_deg_q16[i];
      end else begin
        a   = a - (b >>> i);
        b   = b + (a_prev >>> i);
        ang = ang - atan_deg_q16[i];
      end
    end
    r = (ang + (64'sd1 <<< (Q_FRAC - ANGLE_FRAC_BITS - 1))) >>> (Q_FRAC - ANGLE_FRAC_BITS);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[15:0];
  endfunction

  function automatic atp_pkg::out_word_t predict_tilt(input atp_pkg::in_word_t s);
    atp_pkg::out_word_t o;
    o.pitch_angle = cordic_atan2_deg(longint'(s.accel_z), longint'(s.accel_x));
    o.roll_angle  = cordic_atan2_deg(longint'(s.accel_y), longint'(s.accel_z));
    return o;
  endfunction

  always @(posedge clk) begin
    atp_pkg::out_word_t exp_w;
    int                 errs;
    errs = err_count;
    if (rst_n) begin
      if (in_valid && in_ready) angle_due.push_back(predict_tilt(in_data));
      if (out_valid && out_ready) begin
        if (angle_due.size() == 0) begin
          $display("%0t: unexpected result word pitch %0d roll %0d", $time,
                   out_data.pitch_angle, out_data.roll_angle);
          errs++;
        end else begin
          exp_w = angle_due.pop_front();
          if (out_data.pitch_angle !== exp_w.pitch_angle) begin
            $display("%0t: pitch_angle mismatch: expected %0d, got %0d", $time,
                     exp_w.pitch_angle, out_data.pitch_angle);
            errs++;
          end
          if (out_data.roll_angle !== exp_w.roll_angle) begin
            $display("%0t: roll_angle mismatch: expected %0d, got %0d", $time,
                     exp_w.roll_angle, out_data.roll_angle);
            errs++;
          end
        end
      end
    end
    err_count <= errs;
    pending   <= angle_due.size();
  end

endmodule

>>> tb/tb_accel_tilt_pitch_roll.sv
`timescale 1ns / 1ps

module tb_accel_tilt_pitch_roll;

  localparam int CORDIC_STAGES   = 16;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = CORDIC_STAGES + 10;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  atp_pkg::in_word_t   in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  atp_pkg::out_word_t  out_data;

  int err_count;
  int pending;
  int snd_idle_pct = 19;
  int rcv_idle_pct = 63;
  int quiet_cycles = 0;
  bit hold_req     = 1'b0;
  bit hold_done    = 1'b0;

  always #2 clk = ~clk;

  accel_tilt_pitch_roll #(
    .CORDIC_STAGES  (CORDIC_STAGES),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  tilt_angle_checker #(
    .CORDIC_STAGES  (CORDIC_STAGES),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .err_count(err_count),
    .pending  (pending)
  );

  function automatic logic signed [15:0] rand_axis();
    logic signed [15:0] v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0:       v = 16'sh8000;
          1:       v = 16'sh7fff;
          2:       v = -16'sd1;
          3:       v = 16'sd0;
          default: v = 16'sd1;
        endcase
      end
      1:       v = 16'($urandom_range(16)) - 16'sd8;
      default: v = 16'($urandom());
    endcase
    return v;
  endfunction

  function automatic atp_pkg::in_word_t rand_sample();
    atp_pkg::in_word_t w;
    w.accel_x = rand_axis();
    w.accel_y = rand_axis();
    w.accel_z = rand_axis();
    // diagonals and exact axes now and then
    case ($urandom_range(9))
      0:       w.accel_z = w.accel_x;
      1:       w.accel_z = -w.accel_x;
      2:       w.accel_y = w.accel_z;
      3:       w.accel_y = -w.accel_z;
      4:       w.accel_z = '0;
      5:       w.accel_y = '0;
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_word(input atp_pkg::in_word_t w);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_axes(input logic signed [15:0] x, input logic signed [15:0] y,
                           input logic signed [15:0] z);
    atp_pkg::in_word_t w;
    w.accel_x = x;
    w.accel_y = y;
    w.accel_z = z;
    send_word(w);
  endtask

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero vectors, axes, negative x axis, wrap near +-180 and full-scale corners
    send_axes(16'sd0, 16'sd0, 16'sd0);
    send_axes(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_axes(16'sh8000, 16'sh8000, 16'sh8000);
    send_axes(16'sh7fff, 16'sd0, 16'sd0);
    send_axes(16'sh8000, 16'sd0, 16'sd0);
    send_axes(-16'sd1, 16'sd0, 16'sd0);
    send_axes(16'sd0, 16'sd0, 16'sh8000);
    send_axes(16'sd0, 16'sd1, -16'sd1);
    send_axes(16'sd0, 16'sh7fff, 16'sd0);
    send_axes(16'sd0, 16'sh8000, 16'sd0);
    send_axes(16'sh8000, 16'sd1, 16'sd1);
    send_axes(16'sh8000, -16'sd1, -16'sd1);
    send_axes(-16'sd1, -16'sd1, 16'sd1);
    send_axes(16'sd1, 16'sd1, -16'sd1);
    send_axes(16'sh7fff, 16'sh8000, 16'sh7fff);
    send_axes(16'sh8000, 16'sh7fff, 16'sh8000);
    send_axes(16'sh8000, 16'sh7fff, -16'sd1);
    send_axes(-16'sd1, 16'sh8000, 16'sh7fff);
    send_axes(16'sd12345, -16'sd23456, -16'sd345);
    send_axes(16'sd100, -16'sd200, 16'sd300);
    send_axes(-16'sd300, 16'sd200, -16'sd100);

    repeat (340) send_word(rand_sample());

    snd_idle_pct = 63;
    rcv_idle_pct = 19;
    repeat (340) send_word(rand_sample());

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_req     = 1'b1;
    repeat (350) send_word(rand_sample());

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
